// ===== hw/rtl/mcse_pkg.sv =====
// Shared types, codes and default sizes for the multi-context stack engine.
`default_nettype none

package mcse_pkg;

  localparam int NUM_SLOTS_DEF      = 8;
  localparam int SLOT_CAPACITY_DEF  = 64;
  localparam int MAX_ELEM_BYTES_DEF = 8;

  typedef enum logic [2:0] {
    ACT_CREATE  = 3'd0,
    ACT_DESTROY = 3'd1,
    ACT_PUSH    = 3'd2,
    ACT_POP     = 3'd3,
    ACT_LENGTH  = 3'd4,
    ACT_TOP     = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SIZE   = 3'd1,
    ST_OOM    = 3'd2,
    ST_HANDLE = 3'd3,
    ST_UNDER  = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  stack_id;
    logic [3:0]  elem_bytes;
    logic [63:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  new_handle;
    logic [6:0]  depth_out;
    logic [63:0] top_value;
  } rsp_t;

  // Registered result fields from the slot table; top data comes from memory.
  typedef struct packed {
    logic [2:0] status;
    logic [2:0] new_handle;
    logic [6:0] depth_out;
    logic       top_rd;
  } meta_t;

endpackage

`default_nettype wire

// ===== hw/rtl/multi_context_stack_engine.sv =====
// Top level of the multi-context stack engine.
//
// A pool of NUM_SLOTS stacks shares one element RAM; slot s owns
// SLOT_CAPACITY words. Commands: create, destroy, push, pop, length, top.
// Command channel: a beat is taken on a rising edge with start high and busy
// low. busy stays low: the slot table and RAM take one command every cycle.
// Result channel: done_o strobes for one cycle, in the cycle after the
// command beat, with rsp_o valid in that cycle. A top reads the RAM at the
// command edge and its data arrives with the strobe. Throughput is one
// command per cycle, set by the single RAM port, which a push writes and a
// top reads; a write is visible to a top in the next cycle.
// The receiver cannot stall; each beat must be taken when done_o is high.
// Reset clears all live marks, element sizes and depths at once, so the
// block takes commands from the first cycle after reset. The element RAM is
// not cleared; a top only reads words pushed since the slot's create.
`default_nettype none

module multi_context_stack_engine #(
  parameter int NUM_SLOTS      = mcse_pkg::NUM_SLOTS_DEF,
  parameter int SLOT_CAPACITY  = mcse_pkg::SLOT_CAPACITY_DEF,
  parameter int MAX_ELEM_BYTES = mcse_pkg::MAX_ELEM_BYTES_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire mcse_pkg::cmd_t cmd_i,
  output logic          done_o,
  output mcse_pkg::rsp_t rsp_o
);

  import mcse_pkg::*;

  localparam int Words = NUM_SLOTS * SLOT_CAPACITY;
  localparam int AddrW = (Words > 1) ? $clog2(Words) : 1;
  localparam int DataW = 8 * MAX_ELEM_BYTES;

  logic             accept;
  meta_t            meta;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_addr;
  logic [DataW-1:0] mem_wdata, mem_rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  mcse_slot_table #(
    .NUM_SLOTS      (NUM_SLOTS),
    .SLOT_CAPACITY  (SLOT_CAPACITY),
    .MAX_ELEM_BYTES (MAX_ELEM_BYTES),
    .AddrW          (AddrW),
    .DataW          (DataW)
  ) u_slots (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .cmd_i       (cmd_i),
    .meta_o      (meta),
    .valid_o     (done_o),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata)
  );

  mcse_elem_mem #(
    .Depth (Words),
    .AddrW (AddrW),
    .DataW (DataW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    rsp_o.status     = meta.status;
    rsp_o.new_handle = meta.new_handle;
    rsp_o.depth_out  = meta.depth_out;
    rsp_o.top_value  = meta.top_rd ? 64'(mem_rdata) : 64'd0;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mcse_elem_mem.sv =====
// Element store: single-port synchronous RAM with registered read data.
`default_nettype none

module mcse_elem_mem #(
  parameter int Depth = 512,
  parameter int AddrW = 9,
  parameter int DataW = 64
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [DataW-1:0] wdata_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mcse_slot_table.sv =====
// Slot table: live marks, element sizes and depths; decodes commands, drives the RAM.
`default_nettype none

module mcse_slot_table #(
  parameter int NUM_SLOTS      = 8,
  parameter int SLOT_CAPACITY  = 64,
  parameter int MAX_ELEM_BYTES = 8,
  parameter int AddrW          = 9,
  parameter int DataW          = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire mcse_pkg::cmd_t   cmd_i,
  output mcse_pkg::meta_t       meta_o,
  output logic                  valid_o,
  output logic                  mem_we_o,
  output logic                  mem_re_o,
  output logic      [AddrW-1:0] mem_addr_o,
  output logic      [DataW-1:0] mem_wdata_o
);

  import mcse_pkg::*;

  localparam int SW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int IDW = (SW > 3) ? SW : 3;
  localparam int DW  = $clog2(SLOT_CAPACITY + 1);

  logic [NUM_SLOTS-1:0] live_q, live_d;
  logic [3:0]           eb_q    [NUM_SLOTS];
  logic [3:0]           eb_d    [NUM_SLOTS];
  logic [DW-1:0]        depth_q [NUM_SLOTS];
  logic [DW-1:0]        depth_d [NUM_SLOTS];

  meta_t meta_q, meta_d;
  logic  valid_q;

  action_e       act;
  logic [IDW-1:0] id_w;
  logic [SW-1:0]  id_sel;
  logic           handle_ok;
  logic [DW-1:0]  depth_sel;
  logic [3:0]     eb_sel;
  logic [SW-1:0]  free_idx;
  logic           free_found;
  logic [DW-1:0]  offset;
  logic           push_ok;

  assign act    = action_e'(cmd_i.action);
  assign id_w   = IDW'(cmd_i.stack_id);
  assign id_sel = id_w[SW-1:0];

  always_comb begin
    handle_ok = 1'b0;
    depth_sel = '0;
    eb_sel    = '0;
    if (32'(id_w) < NUM_SLOTS) begin
      handle_ok = live_q[id_sel];
      depth_sel = depth_q[id_sel];
      eb_sel    = eb_q[id_sel];
    end
  end

  // highest-numbered free slot wins
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!live_q[i]) begin
        free_idx   = SW'(i);
        free_found = 1'b1;
      end
    end
  end

  // keep only the low elem_bytes bytes of the pushed word
  always_comb begin
    for (int b = 0; b < MAX_ELEM_BYTES; b++) begin
      mem_wdata_o[b*8 +: 8] = (b < 32'(cmd_i.elem_bytes)) ? cmd_i.push_value[b*8 +: 8] : 8'h00;
    end
  end

  always_comb begin
    live_d   = live_q;
    eb_d     = eb_q;
    depth_d  = depth_q;
    meta_d   = '0;
    mem_we_o = 1'b0;
    mem_re_o = 1'b0;
    push_ok  = 1'b0;
    offset   = depth_sel;
    if (accept_i) begin
      case (act)
        ACT_CREATE: begin
          if (cmd_i.elem_bytes == 4'd0 || 32'(cmd_i.elem_bytes) > MAX_ELEM_BYTES) begin
            meta_d.status = ST_SIZE;
          end else if (!free_found) begin
            meta_d.status = ST_OOM;
          end else begin
            live_d[free_idx]  = 1'b1;
            eb_d[free_idx]    = cmd_i.elem_bytes;
            depth_d[free_idx] = '0;
            meta_d.new_handle = 3'(free_idx);
          end
        end
        ACT_DESTROY, ACT_PUSH, ACT_POP, ACT_LENGTH, ACT_TOP: begin
          if (!handle_ok) begin
            meta_d.status = ST_HANDLE;
          end else begin
            case (act)
              ACT_DESTROY: live_d[id_sel] = 1'b0;
              ACT_PUSH: begin
                if (cmd_i.elem_bytes != eb_sel) begin
                  meta_d.status = ST_SIZE;
                end else if (32'(depth_sel) >= SLOT_CAPACITY) begin
                  meta_d.status = ST_OOM;
                end else begin
                  push_ok         = 1'b1;
                  mem_we_o        = 1'b1;
                  depth_d[id_sel] = DW'(depth_sel + 1'b1);
                end
              end
              ACT_POP: begin
                if (depth_sel == '0) begin
                  meta_d.status = ST_UNDER;
                end else begin
                  depth_d[id_sel] = DW'(depth_sel - 1'b1);
                end
              end
              ACT_LENGTH: meta_d.depth_out = 7'(depth_sel);
              ACT_TOP: begin
                if (depth_sel == '0) begin
                  meta_d.status = ST_UNDER;
                end else begin
                  meta_d.top_rd = 1'b1;
                  mem_re_o      = 1'b1;
                  offset        = DW'(depth_sel - 1'b1);
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // slot s owns words s*SLOT_CAPACITY and up
  assign mem_addr_o = AddrW'(32'(id_sel) * SLOT_CAPACITY + 32'(offset));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q  <= '0;
      valid_q <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        eb_q[i]    <= '0;
        depth_q[i] <= '0;
      end
    end else begin
      live_q  <= live_d;
      eb_q    <= eb_d;
      depth_q <= depth_d;
      valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    meta_q <= meta_d;
  end

  assign meta_o  = meta_q;
  assign valid_o = valid_q;

  a_beat_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> valid_q) else $error("accepted command produced no result beat");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> !valid_q) else $error("result beat without a command");

  a_create_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && act == ACT_CREATE && meta_d.status == ST_OK)
      |=> live_q[$past(free_idx)]) else $error("created slot not live");

  a_push_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_ok |=> depth_q[$past(id_sel)] == DW'($past(depth_sel) + 1'b1))
    else $error("push did not advance depth");

  a_rd_wr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we_o && mem_re_o)) else $error("RAM read and write in one cycle");

endmodule

`default_nettype wire
